@@ hw/rtl/gbq_pkg.sv @@
// ----------------------------------------------------------------------------
// Generation ring queue package
// Shared types, command codes, sequencer states and constants for the
// generation ring broadcast queue.
// ----------------------------------------------------------------------------
package gbq_pkg;

   localparam int RING_DEPTH_DEFAULT = 2048;
   localparam int BURST_DEFAULT      = 64;

   localparam int CSR_W  = 12;
   localparam int GEN_W  = 32;
   localparam int CD_W   = 7;
   localparam int FLD_W  = 16;
   localparam int ENTRY_W = 4 * FLD_W;

   localparam logic [CSR_W-1:0] RING_LENGTH_RESET = 12'd2048;

   localparam logic [CD_W-1:0] COUNTDOWN_START = 7'd100;
   localparam logic [CD_W-1:0] SPEEDUP_ABOVE   = 7'd6;
   localparam logic [CD_W-1:0] SPEEDUP_STEP    = 7'd5;

   typedef enum logic [2:0] {
      CMD_WRITE  = 3'd0,
      CMD_MARK   = 3'd1,
      CMD_WIPE   = 3'd2,
      CMD_RELOAD = 3'd3,
      CMD_TICK   = 3'd4
   } command_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_LOOK,
      ST_EMIT
   } state_type;

   // Outcome of the reader position check.
   typedef struct packed {
      logic overrun;
      logic empty;
   } check_type;

endpackage

@@ hw/rtl/generation_ring_broadcast_queue_core.sv @@
// ----------------------------------------------------------------------------
// Generation ring broadcast queue core
// A ring of map update entries with a generation-counting writer and one
// reader that is dropped and sent to a full reload when it is lapped.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the req_ channel: a command with an entry and a busy flag.
// Write, mark, wipe and reload requests are accepted, then executed, and
// give no result. A service tick hands out up to BURST entries on the rsp_
// channel, one item per entry, with rsp_last set on the final one; a tick
// during a reload countdown gives at most the single reload item. After the
// tick is executed, each entry takes one ring read, one pass through the
// shared position check and one output state, and the next read waits until
// the receiver has taken the item. The ring memory has one read port, so
// entries leave one at a time.
// req_ready is high only while the sequencer is idle, so one item is worked
// on at a time. If the receiver stalls, the pending result stays in the
// output register and the sequencer waits. Reset clears offsets,
// generations, the reader and the countdown, and sets the ring length to
// 2048 (clamped to the memory depth); ring contents are not cleared.
// The csr_ port takes the ring length at any time; write it only when idle.
// ----------------------------------------------------------------------------
module generation_ring_broadcast_queue_core #(
   parameter int RING_DEPTH = gbq_pkg::RING_DEPTH_DEFAULT,
   parameter int BURST      = gbq_pkg::BURST_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_command,
   input  logic [gbq_pkg::FLD_W-1:0]   req_pos_x,
   input  logic [gbq_pkg::FLD_W-1:0]   req_pos_y,
   input  logic [gbq_pkg::FLD_W-1:0]   req_pos_z,
   input  logic [gbq_pkg::FLD_W-1:0]   req_block_code,
   input  logic                        req_output_busy,
   // Result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_kind,
   output logic [gbq_pkg::FLD_W-1:0]   rsp_out_x,
   output logic [gbq_pkg::FLD_W-1:0]   rsp_out_y,
   output logic [gbq_pkg::FLD_W-1:0]   rsp_out_z,
   output logic [gbq_pkg::FLD_W-1:0]   rsp_out_block,
   output logic                        rsp_last,
   // Configuration channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [gbq_pkg::CSR_W-1:0]   csr_data
);
   import gbq_pkg::*;

   localparam int OFS_W = $clog2(RING_DEPTH);
   localparam int LEN_W = $clog2(RING_DEPTH + 1);
   localparam int CNT_W = $clog2(BURST + 1);

   // Sequencer and architectural state.
   state_type          state_ff, state_in;
   logic [CSR_W-1:0]   ring_length_ff;
   logic [OFS_W-1:0]   wr_ofs_ff, wr_ofs_in;
   logic [GEN_W-1:0]   wr_gen_ff, wr_gen_in;
   logic [LEN_W-1:0]   wrap_len_ff, wrap_len_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [OFS_W-1:0]   rd_ofs_ff, rd_ofs_in;
   logic [GEN_W-1:0]   rd_gen_ff, rd_gen_in;
   logic [CD_W-1:0]    cd_ff, cd_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // Latched request item.
   logic [2:0]         cmd_ff;
   logic [FLD_W-1:0]   x_ff, y_ff, z_ff, blk_ff;
   logic               busy_ff;

   // Result register.
   logic               res_kind_ff, res_kind_in;
   logic [FLD_W-1:0]   res_x_ff, res_x_in;
   logic [FLD_W-1:0]   res_y_ff, res_y_in;
   logic [FLD_W-1:0]   res_z_ff, res_z_in;
   logic [FLD_W-1:0]   res_blk_ff, res_blk_in;
   logic               res_last_ff, res_last_in;

   logic [LEN_W-1:0]   len;
   logic [LEN_W-1:0]   wr_ofs_inc;
   logic [LEN_W-1:0]   rd_ofs_inc;
   logic               mem_wr_en;
   logic               mem_rd_en;
   logic [ENTRY_W-1:0] mem_rd_data;
   check_type          chk;

   // Effective ring length: the register clamped to one up to the depth.
   always_comb begin
      if (ring_length_ff == '0) begin
         len = LEN_W'(1);
      end else if (32'(ring_length_ff) > 32'(RING_DEPTH)) begin
         len = LEN_W'(RING_DEPTH);
      end else begin
         len = LEN_W'(ring_length_ff);
      end
   end

   assign wr_ofs_inc = LEN_W'(wr_ofs_ff) + LEN_W'(1);
   assign rd_ofs_inc = LEN_W'(rd_ofs_ff) + LEN_W'(1);

   gbq_ring_mem #(
      .DEPTH  (RING_DEPTH),
      .ADDR_W (OFS_W)
   ) u_ring_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_ofs_ff),
      .wr_data ({blk_ff, z_ff, y_ff, x_ff}),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_ofs_ff),
      .rd_data (mem_rd_data)
   );

   // The one position check serves the first look at a tick and the
   // look-ahead after every entry read, always on the registered state.
   gbq_check #(
      .OFS_W (OFS_W),
      .LEN_W (LEN_W)
   ) u_check (
      .read_gen  (rd_gen_ff),
      .write_gen (wr_gen_ff),
      .read_ofs  (rd_ofs_ff),
      .write_ofs (wr_ofs_ff),
      .wrap_len  (wrap_len_ff),
      .cur_len   (len),
      .result    (chk)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid     = (state_ff == ST_EMIT);
   assign rsp_kind      = res_kind_ff;
   assign rsp_out_x     = res_x_ff;
   assign rsp_out_y     = res_y_ff;
   assign rsp_out_z     = res_z_ff;
   assign rsp_out_block = res_blk_ff;
   assign rsp_last      = res_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ring_length_ff <= RING_LENGTH_RESET;
         wr_ofs_ff      <= '0;
         wr_gen_ff      <= '0;
         wrap_len_ff    <= '0;
         rd_valid_ff    <= 1'b0;
         rd_ofs_ff      <= '0;
         rd_gen_ff      <= '0;
         cd_ff          <= '0;
         count_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         wr_ofs_ff   <= wr_ofs_in;
         wr_gen_ff   <= wr_gen_in;
         wrap_len_ff <= wrap_len_in;
         rd_valid_ff <= rd_valid_in;
         rd_ofs_ff   <= rd_ofs_in;
         rd_gen_ff   <= rd_gen_in;
         cd_ff       <= cd_in;
         count_ff    <= count_in;
         if (csr_valid && csr_ready) begin
            ring_length_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff  <= req_command;
         x_ff    <= req_pos_x;
         y_ff    <= req_pos_y;
         z_ff    <= req_pos_z;
         blk_ff  <= req_block_code;
         busy_ff <= req_output_busy;
      end
      res_kind_ff <= res_kind_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_z_ff    <= res_z_in;
      res_blk_ff  <= res_blk_in;
      res_last_ff <= res_last_in;
   end

   always_comb begin
      logic [CD_W-1:0] cd_dec;
      logic            reader_idle;

      state_in    = state_ff;
      wr_ofs_in   = wr_ofs_ff;
      wr_gen_in   = wr_gen_ff;
      wrap_len_in = wrap_len_ff;
      rd_valid_in = rd_valid_ff;
      rd_ofs_in   = rd_ofs_ff;
      rd_gen_in   = rd_gen_ff;
      cd_in       = cd_ff;
      count_in    = count_ff;
      res_kind_in = res_kind_ff;
      res_x_in    = res_x_ff;
      res_y_in    = res_y_ff;
      res_z_in    = res_z_ff;
      res_blk_in  = res_blk_ff;
      res_last_in = res_last_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      cd_dec      = cd_ff - CD_W'(1);
      reader_idle = rd_valid_ff && (rd_ofs_ff == wr_ofs_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (cmd_ff)
               CMD_WRITE: begin
                  mem_wr_en = 1'b1;
                  if (wr_ofs_inc >= len) begin
                     wr_ofs_in   = '0;
                     wr_gen_in   = wr_gen_ff + GEN_W'(1);
                     wrap_len_in = len;
                  end else begin
                     wr_ofs_in = OFS_W'(wr_ofs_inc);
                  end
               end
               CMD_MARK: begin
                  rd_ofs_in   = wr_ofs_ff;
                  rd_gen_in   = wr_gen_ff;
                  rd_valid_in = 1'b1;
               end
               CMD_WIPE: begin
                  rd_valid_in = 1'b0;
                  rd_ofs_in   = '0;
                  rd_gen_in   = '0;
               end
               CMD_RELOAD: begin
                  cd_in = CD_W'(1);
               end
               CMD_TICK: begin
                  if (cd_ff != '0) begin
                     // Countdown running: it pauses while output is busy.
                     if (!busy_ff) begin
                        if (cd_ff > CD_W'(1)) begin
                           // With no writes since the last tick, and
                           // above SPEEDUP_ABOVE, the countdown runs faster.
                           if (cd_dec > SPEEDUP_ABOVE && reader_idle) begin
                              cd_in = cd_dec - SPEEDUP_STEP;
                           end else begin
                              cd_in = cd_dec;
                           end
                           rd_ofs_in   = wr_ofs_ff;
                           rd_valid_in = 1'b1;
                        end else begin
                           cd_in       = '0;
                           res_kind_in = 1'b1;
                           res_x_in    = '0;
                           res_y_in    = '0;
                           res_z_in    = '0;
                           res_blk_in  = '0;
                           res_last_in = 1'b1;
                           state_in    = ST_EMIT;
                        end
                     end
                  end else if (rd_valid_ff) begin
                     count_in = '0;
                     if (chk.overrun) begin
                        rd_valid_in = 1'b0;
                        rd_ofs_in   = '0;
                        rd_gen_in   = '0;
                        cd_in       = COUNTDOWN_START;
                     end else if (!chk.empty) begin
                        state_in = ST_READ;
                     end
                  end
               end
               default: begin
                  // Unknown commands are dropped.
               end
            endcase
         end

         ST_READ: begin
            // Fetch the entry and move the reader past it.
            mem_rd_en = 1'b1;
            count_in  = count_ff + CNT_W'(1);
            if (rd_ofs_inc >= len) begin
               rd_ofs_in = '0;
               rd_gen_in = rd_gen_ff + GEN_W'(1);
            end else begin
               rd_ofs_in = OFS_W'(rd_ofs_inc);
            end
            state_in = ST_LOOK;
         end

         ST_LOOK: begin
            // Look ahead: this entry is the last if the burst is full or
            // the next check would stop the tick.
            res_kind_in = 1'b0;
            res_x_in    = mem_rd_data[FLD_W-1:0];
            res_y_in    = mem_rd_data[2*FLD_W-1:FLD_W];
            res_z_in    = mem_rd_data[3*FLD_W-1:2*FLD_W];
            res_blk_in  = mem_rd_data[4*FLD_W-1:3*FLD_W];
            res_last_in = (count_ff == CNT_W'(BURST)) || chk.overrun || chk.empty;
            if (count_ff != CNT_W'(BURST) && chk.overrun) begin
               rd_valid_in = 1'b0;
               rd_ofs_in   = '0;
               rd_gen_in   = '0;
               cd_in       = COUNTDOWN_START;
            end
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (rsp_ready) begin
               state_in = res_last_ff ? ST_IDLE : ST_READ;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/gbq_ring_mem.sv @@
// ----------------------------------------------------------------------------
// Ring entry memory
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module gbq_ring_mem #(
   parameter int DEPTH  = gbq_pkg::RING_DEPTH_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [gbq_pkg::ENTRY_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [gbq_pkg::ENTRY_W-1:0] rd_data
);
   import gbq_pkg::*;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/gbq_check.sv @@
// ----------------------------------------------------------------------------
// Reader position check
// Compares the reader's generation and offset against the writer's and
// reports whether the reader has been lapped or has caught up.
// ----------------------------------------------------------------------------
module gbq_check #(
   parameter int OFS_W = 11,
   parameter int LEN_W = 12
) (
   input  logic [gbq_pkg::GEN_W-1:0] read_gen,
   input  logic [gbq_pkg::GEN_W-1:0] write_gen,
   input  logic [OFS_W-1:0]          read_ofs,
   input  logic [OFS_W-1:0]          write_ofs,
   input  logic [LEN_W-1:0]          wrap_len,
   input  logic [LEN_W-1:0]          cur_len,
   output gbq_pkg::check_type        result
);
   import gbq_pkg::*;

   logic one_behind;

   // One generation behind is still fine if the ring length has not moved
   // and the writer has not yet passed the reader's offset.
   assign one_behind = (read_gen + GEN_W'(1) == write_gen) &&
                       (wrap_len == cur_len) && (write_ofs < read_ofs);

   assign result.overrun = (read_gen != write_gen) && !one_behind;
   assign result.empty   = (read_ofs == write_ofs);

endmodule

@@ dv/generation_ring_broadcast_queue_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Generation ring broadcast queue core testbench
// Drives commands into the queue core over its request handshake and checks
// every handed-out entry and reload notice against a cycle-free model of the
// ring. A short table of hand-picked items comes first, then random sequences
// of marks, writes, service ticks, reloads, wipes and spare codes over several
// ring lengths, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module generation_ring_broadcast_queue_core_tb;
   import gbq_pkg::*;

   localparam int RING_DEPTH    = RING_DEPTH_DEFAULT;
   localparam int BURST         = BURST_DEFAULT;
   localparam int MAX_GAP       = 6;
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASE_ITEMS   = 25;
   localparam int TIMEOUT_NS    = 20_000_000;

   // Command codes that the core must ignore.
   localparam logic [2:0] CMD_SPARE_A = 3'd5;
   localparam logic [2:0] CMD_SPARE_B = 3'd6;
   localparam logic [2:0] CMD_SPARE_C = 3'd7;

   // Kinds of item on the result channel.
   localparam logic KIND_ENTRY  = 1'b0;
   localparam logic KIND_RELOAD = 1'b1;

   typedef struct packed {
      logic [2:0]       command;
      logic [FLD_W-1:0] pos_x;
      logic [FLD_W-1:0] pos_y;
      logic [FLD_W-1:0] pos_z;
      logic [FLD_W-1:0] block_code;
      logic             output_busy;
   } request_t;

   typedef struct packed {
      logic             kind;
      logic [FLD_W-1:0] out_x;
      logic [FLD_W-1:0] out_y;
      logic [FLD_W-1:0] out_z;
      logic [FLD_W-1:0] out_block;
      logic             last;
   } update_t;

   // A directed row either sends one item or loads the ring length. Its
   // expectation is either taken from the model or typed in by hand.
   typedef enum logic [1:0] {ROW_REQUEST, ROW_LENGTH} row_kind_t;
   typedef enum logic [1:0] {WANT_MODEL, WANT_NOTHING, WANT_ONE} row_want_t;

   typedef struct packed {
      row_kind_t        kind;
      request_t         rq;
      row_want_t        want;
      update_t          fixed;
      logic [CSR_W-1:0] length;
   } stim_row_t;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [2:0]       req_command;
   logic [FLD_W-1:0] req_pos_x;
   logic [FLD_W-1:0] req_pos_y;
   logic [FLD_W-1:0] req_pos_z;
   logic [FLD_W-1:0] req_block_code;
   logic             req_output_busy;
   logic             rsp_valid;
   logic             rsp_ready;
   logic             rsp_kind;
   logic [FLD_W-1:0] rsp_out_x;
   logic [FLD_W-1:0] rsp_out_y;
   logic [FLD_W-1:0] rsp_out_z;
   logic [FLD_W-1:0] rsp_out_block;
   logic             rsp_last;
   logic             csr_valid;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_data;

   generation_ring_broadcast_queue_core #(
      .RING_DEPTH (RING_DEPTH),
      .BURST      (BURST)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_block_code  (req_block_code),
      .req_output_busy (req_output_busy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_out_block   (rsp_out_block),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   // ------------------------------------------------------------------------
   // Model state. It starts at the reset values, as reset is applied once.
   // ------------------------------------------------------------------------
   logic [ENTRY_W-1:0] ring_store [RING_DEPTH];
   int unsigned        wr_pos      = 0;
   logic [GEN_W-1:0]   wr_gen      = '0;
   int unsigned        lap_len     = 0;
   logic               rd_live     = 1'b0;
   int unsigned        rd_pos      = 0;
   logic [GEN_W-1:0]   rd_gen      = '0;
   logic [CD_W-1:0]    reload_wait = '0;
   logic [CSR_W-1:0]   ring_len    = RING_LENGTH_RESET;

   // Ring lengths used by the random phases; the first and the fifth also
   // drive every bit of the register both ways.
   logic [CSR_W-1:0] phase_lengths [9] = '{12'd4095, 12'd3, 12'd1, 12'd64, 12'd0,
                                           12'd200, 12'd17, 12'd2048, 12'd100};

   update_t   fresh_updates[$];   // results of the item just accepted
   update_t   pending_updates[$]; // results still to come from the core
   stim_row_t directed_rows[$];

   bit no_idle = 1'b0;
   int mismatch_count  = 0;
   int requests_sent   = 0;
   int updates_checked = 0;
   int reloads_checked = 0;
   int laps_seen       = 0;
   int lengths_loaded  = 0;
   int phase_items     = 0;

   // The clock runs with a 20 ns period, low half first.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // The watchdog ends a run that hangs.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   // A zero length behaves as one entry, and the length never exceeds the
   // depth of the memory.
   function automatic int unsigned usable_length();
      if (ring_len == '0) begin
         return 1;
      end
      if (ring_len > RING_DEPTH) begin
         return RING_DEPTH;
      end
      return ring_len;
   endfunction

   // ------------------------------------------------------------------------
   // Ring queue model: applies one accepted item and leaves the results it
   // causes in fresh_updates.
   // ------------------------------------------------------------------------
   task automatic ring_queue_step(input request_t rq);
      int unsigned len;
      int unsigned slot;
      bit          stop;
      bit          quiet_reader;
      update_t     u;
      len = usable_length();
      fresh_updates.delete();
      case (rq.command)
         CMD_WRITE: begin
            slot = (wr_pos >= RING_DEPTH) ? 0 : wr_pos;
            ring_store[slot] = {rq.block_code, rq.pos_z, rq.pos_y, rq.pos_x};
            wr_pos = slot + 1;
            if (wr_pos >= len) begin
               wr_pos  = 0;
               wr_gen  = wr_gen + 1'b1;
               lap_len = len;
            end
         end
         CMD_MARK: begin
            rd_pos  = wr_pos;
            rd_gen  = wr_gen;
            rd_live = 1'b1;
         end
         CMD_WIPE: begin
            rd_live = 1'b0;
            rd_pos  = 0;
            rd_gen  = '0;
         end
         CMD_RELOAD: begin
            reload_wait = 7'd1;
         end
         CMD_TICK: begin
            if (reload_wait != '0) begin
               // While output is busy the countdown holds still.
               if (!rq.output_busy) begin
                  if (reload_wait > 7'd1) begin
                     quiet_reader = rd_live && (rd_pos == wr_pos);
                     reload_wait  = reload_wait - 7'd1;
                     if (reload_wait > SPEEDUP_ABOVE && quiet_reader) begin
                        reload_wait = reload_wait - SPEEDUP_STEP;
                     end
                     rd_pos  = wr_pos;
                     rd_live = 1'b1;
                  end else begin
                     reload_wait = '0;
                     u      = '0;
                     u.kind = KIND_RELOAD;
                     u.last = 1'b1;
                     fresh_updates.push_back(u);
                  end
               end
            end else if (rd_live) begin
               stop = 1'b0;
               while (fresh_updates.size() < BURST && !stop) begin
                  // Differing generations are fine only when the writer has
                  // wrapped once at this length and is still behind us.
                  if (rd_gen != wr_gen &&
                      !(rd_gen + 1'b1 == wr_gen && lap_len == len && wr_pos < rd_pos)) begin
                     rd_live     = 1'b0;
                     rd_pos      = 0;
                     rd_gen      = '0;
                     reload_wait = COUNTDOWN_START;
                     laps_seen++;
                     stop = 1'b1;
                  end else if (rd_pos == wr_pos) begin
                     stop = 1'b1;
                  end else begin
                     slot   = (rd_pos >= RING_DEPTH) ? 0 : rd_pos;
                     u      = '0;
                     u.kind = KIND_ENTRY;
                     {u.out_block, u.out_z, u.out_y, u.out_x} = ring_store[slot];
                     fresh_updates.push_back(u);
                     rd_pos = slot + 1;
                     if (rd_pos >= len) begin
                        rd_pos = 0;
                        rd_gen = rd_gen + 1'b1;
                     end
                  end
               end
               if (fresh_updates.size() > 0) begin
                  u = fresh_updates.pop_back();
                  u.last = 1'b1;
                  fresh_updates.push_back(u);
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Request side. Each item waits a random number of cycles first; valid
   // then stays high with the payload held until the core takes the item.
   // The model is advanced at the edge of acceptance.
   // ------------------------------------------------------------------------
   task automatic offer_request(input request_t rq);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= rq.command;
      req_pos_x       <= rq.pos_x;
      req_pos_y       <= rq.pos_y;
      req_pos_z       <= rq.pos_z;
      req_block_code  <= rq.block_code;
      req_output_busy <= rq.output_busy;
      do @(posedge clock); while (!req_ready);
      ring_queue_step(rq);
      requests_sent++;
   endtask

   // Sends one item of the given command with random content and queues
   // what the model predicts for it.
   task automatic issue(input logic [2:0] cmd);
      request_t rq;
      rq.command     = cmd;
      rq.pos_x       = 16'($urandom);
      rq.pos_y       = 16'($urandom);
      rq.pos_z       = 16'($urandom);
      rq.block_code  = 16'($urandom);
      rq.output_busy = ($urandom_range(0, 3) == 0);
      offer_request(rq);
      foreach (fresh_updates[i]) begin
         pending_updates.push_back(fresh_updates[i]);
      end
      phase_items++;
   endtask

   // Holds the request side until every queued result has come out, then
   // lets the core finish any item that gives no result.
   task automatic settle_queue();
      req_valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The ring length is only changed while the core is idle.
   task automatic load_ring_length(input logic [CSR_W-1:0] value);
      settle_queue();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      ring_len = value;
      lengths_loaded++;
   endtask

   // ------------------------------------------------------------------------
   // Builders for the directed table.
   // ------------------------------------------------------------------------
   task automatic row_model(input logic [2:0] cmd, input logic [FLD_W-1:0] x,
                            input logic [FLD_W-1:0] y, input logic [FLD_W-1:0] z,
                            input logic [FLD_W-1:0] blk, input logic busy);
      stim_row_t row;
      row      = '0;
      row.kind = ROW_REQUEST;
      row.want = WANT_MODEL;
      row.rq   = '{cmd, x, y, z, blk, busy};
      directed_rows.push_back(row);
   endtask

   task automatic row_quiet(input logic [2:0] cmd, input logic busy);
      stim_row_t row;
      row                = '0;
      row.kind           = ROW_REQUEST;
      row.want           = WANT_NOTHING;
      row.rq.command     = cmd;
      row.rq.output_busy = busy;
      directed_rows.push_back(row);
   endtask

   task automatic row_single(input logic [2:0] cmd, input logic busy, input logic kind,
                             input logic [FLD_W-1:0] x, input logic [FLD_W-1:0] y,
                             input logic [FLD_W-1:0] z, input logic [FLD_W-1:0] blk);
      stim_row_t row;
      row                = '0;
      row.kind           = ROW_REQUEST;
      row.want           = WANT_ONE;
      row.rq.command     = cmd;
      row.rq.output_busy = busy;
      row.fixed          = '{kind, x, y, z, blk, 1'b1};
      directed_rows.push_back(row);
   endtask

   task automatic row_length(input logic [CSR_W-1:0] value);
      stim_row_t row;
      row        = '0;
      row.kind   = ROW_LENGTH;
      row.length = value;
      directed_rows.push_back(row);
   endtask

   // ------------------------------------------------------------------------
   // Result side. The receiver stalls a random number of cycles before each
   // item, except in the phases that run without gaps.
   // ------------------------------------------------------------------------
   initial begin : rsp_flow
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Every item taken from the result channel is compared with the oldest
   // expectation, field by field.
   always @(posedge clock) begin : update_check
      update_t got;
      update_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_kind, rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_block, rsp_last};
         if (pending_updates.size() == 0) begin
            flag_mismatch($sformatf("unexpected item kind=%0d x=%h y=%h z=%h block=%h last=%0d",
                                    got.kind, got.out_x, got.out_y, got.out_z,
                                    got.out_block, got.last));
         end else begin
            want = pending_updates.pop_front();
            if (got.kind !== want.kind || got.out_x !== want.out_x ||
                got.out_y !== want.out_y || got.out_z !== want.out_z ||
                got.out_block !== want.out_block || got.last !== want.last) begin
               flag_mismatch($sformatf(
                  "got kind=%0d %h/%h/%h/%h last=%0d, want kind=%0d %h/%h/%h/%h last=%0d",
                  got.kind, got.out_x, got.out_y, got.out_z, got.out_block, got.last,
                  want.kind, want.out_x, want.out_y, want.out_z, want.out_block,
                  want.last));
            end
            updates_checked++;
            if (want.kind == KIND_RELOAD) begin
               reloads_checked++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      stim_row_t row;
      int        pick;
      int        burst_len;
      bit        long_burst_done;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_command     <= CMD_WRITE;
      req_pos_x       <= '0;
      req_pos_y       <= '0;
      req_pos_z       <= '0;
      req_block_code  <= '0;
      req_output_busy <= 1'b0;
      csr_valid       <= 1'b0;
      csr_data        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // After reset the reader is invalid, so the first tick gives nothing.
      row_quiet(CMD_TICK, 1'b0);
      row_quiet(CMD_MARK, 1'b0);
      // All-ones and all-zero entries; the busy flag only matters while a
      // countdown is running.
      row_model(CMD_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      row_single(CMD_TICK, 1'b0, KIND_ENTRY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      row_model(CMD_WRITE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      row_single(CMD_TICK, 1'b1, KIND_ENTRY, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      // An unused command code is ignored.
      row_quiet(CMD_SPARE_A, 1'b1);
      // A reload request: a busy tick pauses, the next tick gives the notice.
      row_quiet(CMD_RELOAD, 1'b0);
      row_quiet(CMD_TICK, 1'b1);
      row_single(CMD_TICK, 1'b0, KIND_RELOAD, '0, '0, '0, '0);
      // With four entries, five writes after the mark lap the reader: the
      // tick drops it and starts the long countdown, which a reload request
      // then cuts short.
      row_length(12'd4);
      row_quiet(CMD_MARK, 1'b0);
      repeat (5) begin
         row_model(CMD_WRITE, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 1'b0);
      end
      row_quiet(CMD_TICK, 1'b0);
      row_quiet(CMD_RELOAD, 1'b0);
      row_single(CMD_TICK, 1'b0, KIND_RELOAD, '0, '0, '0, '0);
      // The writer wraps once but stays behind the reader, which is allowed.
      row_quiet(CMD_MARK, 1'b0);
      repeat (2) begin
         row_model(CMD_WRITE, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 1'b0);
      end
      row_model(CMD_TICK, '0, '0, '0, '0, 1'b0);
      // A zero length acts as a single entry.
      row_length(12'd0);
      row_model(CMD_WRITE, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 1'b0);
      row_model(CMD_TICK, '0, '0, '0, '0, 1'b0);
      // A length above the memory depth is clamped to it.
      row_length(12'd4095);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_LENGTH) begin
            load_ring_length(row.length);
         end else begin
            offer_request(row.rq);
            if (row.want == WANT_ONE) begin
               pending_updates.push_back(row.fixed);
            end else if (row.want == WANT_MODEL) begin
               foreach (fresh_updates[j]) begin
                  pending_updates.push_back(fresh_updates[j]);
               end
            end
         end
      end

      // Random phases, one ring length each. Most of the traffic is a mark
      // now and then, a few writes and a tick; the rest keeps countdowns
      // moving, fills long bursts, or is plain noise.
      foreach (phase_lengths[p]) begin
         load_ring_length(phase_lengths[p]);
         no_idle         = (p == 3 || p == 7);
         phase_items     = 0;
         long_burst_done = 1'b0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 24) == 0) begin
               settle_queue();
            end
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
               if (!rd_live || $urandom_range(0, 3) == 0) begin
                  issue(CMD_MARK);
               end
               burst_len = $urandom_range(0, 6);
               // Small rings get write runs around the ring length, so that
               // both the allowed wrap and the lap occur.
               if (usable_length() <= 20 && $urandom_range(0, 2) == 0) begin
                  burst_len = $urandom_range(0, usable_length() + 1);
               end
               repeat (burst_len) issue(CMD_WRITE);
               issue(CMD_TICK);
            end else if (pick < 67 && !long_burst_done && usable_length() >= 80 &&
                         reload_wait == '0) begin
               // More entries than one tick may hand out.
               long_burst_done = 1'b1;
               issue(CMD_MARK);
               repeat ($urandom_range(BURST + 2, BURST + 8)) issue(CMD_WRITE);
               issue(CMD_TICK);
               issue(CMD_TICK);
            end else if (pick < 88) begin
               if ($urandom_range(0, 4) == 0) begin
                  issue(CMD_RELOAD);
               end
               repeat ($urandom_range(3, 8)) begin
                  if ($urandom_range(0, 3) == 0) begin
                     issue(CMD_WRITE);
                  end
                  issue(CMD_TICK);
               end
            end else begin
               if ($urandom_range(0, 3) == 0) begin
                  issue(CMD_WIPE);
               end else begin
                  issue(3'($urandom_range(0, CMD_SPARE_C)));
               end
            end
         end
      end

      settle_queue();
      $display("Sent %0d requests over %0d ring length settings; checked %0d items,",
               requests_sent, lengths_loaded, updates_checked);
      $display("including %0d reload notices, with %0d lapped readers.",
               reloads_checked, laps_seen);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ generation_ring_broadcast_queue_core.f @@
hw/rtl/gbq_pkg.sv
hw/rtl/gbq_ring_mem.sv
hw/rtl/gbq_check.sv
hw/rtl/generation_ring_broadcast_queue_core.sv
dv/generation_ring_broadcast_queue_core_tb.sv
